// ----- design/lzd_pkg.sv -----
// Package for the LZ77 triple decoder: item structs, field widths and defaults.
// It depends on nothing. The decoder top level and the bench import it.
package lzd_pkg;

  localparam int unsigned OFF_W  = 13;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned BYTE_W = 8;

  localparam int unsigned LZD_WINDOW_SIZE = 4096;
  localparam int unsigned LZD_MAX_LENGTH  = 63;

  typedef struct packed {
    logic [OFF_W-1:0]  match_offset;
    logic [LEN_W-1:0]  match_length;
    logic [BYTE_W-1:0] literal_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_of_triple;
    logic              bad_offset;
  } out_item_t;

endpackage

// ----- design/lzd_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// It has no dependencies and is used for the history ring.
module lzd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/lzd_wrap_add.sv -----
// Shared ring-address adder: (a + b) modulo the window size, with a, b below it.
// It has no dependencies; the decoder sequencer drives it in every state.
module lzd_wrap_add #(
  parameter int unsigned WINDOW_SIZE = 4096
) (
  input  logic [$clog2(WINDOW_SIZE)-1:0] a_i,
  input  logic [$clog2(WINDOW_SIZE)-1:0] b_i,
  output logic [$clog2(WINDOW_SIZE)-1:0] sum_o
);

  localparam int unsigned PW = $clog2(WINDOW_SIZE);

  logic [PW:0] raw;
  logic [PW:0] wrapped;

  always_comb begin
    raw     = {1'b0, a_i} + {1'b0, b_i};
    wrapped = raw - (PW+1)'(WINDOW_SIZE);
    if (raw >= (PW+1)'(WINDOW_SIZE)) begin
      sum_o = wrapped[PW-1:0];
    end else begin
      sum_o = raw[PW-1:0];
    end
  end

endmodule

// ----- design/lz77_triple_decoder.sv -----
// LZ77 triple decoder top level: sequencer, history ring and output register.
// Depends on lzd_pkg, lzd_ram and lzd_wrap_add.
//
// Usage:
//   The input channel (in_valid_i, in_stall_o, in_item_i) takes one triple:
//   offset, length and literal. The output channel (out_valid_o, out_stall_i,
//   out_item_o) gives the decoded bytes, one item each, the copied run first
//   and the literal last, marked by last_of_triple. A nonzero-length triple
//   whose offset is zero or past the filled history gives only its literal, flagged
//   bad_offset. Every emitted byte goes into a ring history of WINDOW_SIZE bytes.
// Sequencing:
//   One triple is worked at a time; in_stall_o is high until it is done.
//   Each copied byte takes a ring read (ST_READ), then an output load and
//   ring write (ST_COPY); the literal takes an output load and ring write
//   (ST_LIT). After a literal-only accept the first result is loaded in
//   ST_LIT; after a copy accept, in ST_COPY once ST_READ has read the ring.
//   The single ring read port and the one shared address adder set this order.
// Reset and stalls:
//   Reset empties the history (fill count and write pointer to zero) and the
//   output register. While an item is held under out_stall_i, it stays put
//   and the sequencer waits in ST_COPY or ST_LIT; no byte is lost or repeated.
module lz77_triple_decoder
  import lzd_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = LZD_WINDOW_SIZE
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned PW = $clog2(WINDOW_SIZE);
  localparam int unsigned FW = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned XW = (FW > OFF_W) ? FW : OFF_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_LIT
  } state_e;

  state_e            state_q, state_d;
  logic [PW-1:0]     wp_q, wp_d;
  logic [PW-1:0]     rd_q, rd_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] lit_q, lit_d;
  logic              bad_q, bad_d;
  out_item_t         out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic [PW-1:0]     ua, ub, usum;
  logic              ram_we, ram_re;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  logic              in_acc, out_free, off_bad;
  logic [LEN_W-1:0]  len_clamp;
  logic [XW-1:0]     off_x, fill_x;
  logic [XW:0]       rd_delta;
  logic [FW-1:0]     fill_inc;

  lzd_wrap_add #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_wrap_add (
    .a_i  (ua),
    .b_i  (ub),
    .sum_o(usum)
  );

  lzd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(WINDOW_SIZE)
  ) u_history (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_q),
    .rdata_o(ram_rdata)
  );

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    if (in_item_i.match_length > LEN_W'(LZD_MAX_LENGTH)) begin
      len_clamp = LEN_W'(LZD_MAX_LENGTH);
    end else begin
      len_clamp = in_item_i.match_length;
    end
    off_x    = XW'(in_item_i.match_offset);
    fill_x   = XW'(fill_q);
    off_bad  = (in_item_i.match_offset == '0) || (off_x > fill_x);
    rd_delta = (XW+1)'(WINDOW_SIZE) - {1'b0, off_x};
    fill_inc = (fill_q == FW'(WINDOW_SIZE)) ? fill_q : fill_q + 1'b1;
  end

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rd_d      = rd_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    lit_d     = lit_q;
    bad_d     = bad_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    ua        = wp_q;
    ub        = rd_delta[PW-1:0];
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = ram_rdata;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          lit_d = in_item_i.literal_byte;
          if (len_clamp == '0) begin
            bad_d   = 1'b0;
            state_d = ST_LIT;
          end else if (off_bad) begin
            bad_d   = 1'b1;
            state_d = ST_LIT;
          end else begin
            bad_d   = 1'b0;
            rd_d    = usum;
            cnt_d   = len_clamp;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        ua      = rd_q;
        ub      = PW'(1);
        rd_d    = usum;
        state_d = ST_COPY;
      end
      ST_COPY: begin
        ub = PW'(1);
        if (out_free) begin
          out_d.data_byte      = ram_rdata;
          out_d.last_of_triple = 1'b0;
          out_d.bad_offset     = 1'b0;
          out_vld_d            = 1'b1;
          ram_we               = 1'b1;
          wp_d                 = usum;
          fill_d               = fill_inc;
          cnt_d                = cnt_q - 1'b1;
          state_d              = (cnt_q == LEN_W'(1)) ? ST_LIT : ST_READ;
        end
      end
      ST_LIT: begin
        ub        = PW'(1);
        ram_wdata = lit_q;
        if (out_free) begin
          out_d.data_byte      = lit_q;
          out_d.last_of_triple = 1'b1;
          out_d.bad_offset     = bad_q;
          out_vld_d            = 1'b1;
          ram_we               = 1'b1;
          wp_d                 = usum;
          fill_d               = fill_inc;
          state_d              = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      rd_q      <= '0;
      fill_q    <= '0;
      cnt_q     <= '0;
      lit_q     <= '0;
      bad_q     <= 1'b0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rd_q      <= rd_d;
      fill_q    <= fill_d;
      cnt_q     <= cnt_d;
      lit_q     <= lit_d;
      bad_q     <= bad_d;
      out_q     <= out_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(WINDOW_SIZE))
    else $error("fill count above window size");

  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, wp_q} < (PW+1)'(WINDOW_SIZE))
    else $error("write pointer outside ring");

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.bad_offset |-> out_item_o.last_of_triple)
    else $error("bad_offset on a non-final item");

  a_lit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_item_i.match_length == '0) |=> state_q == ST_LIT)
    else $error("zero-length triple did not go to literal");

  a_write_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> out_vld_q)
    else $error("ring written without an output item");
`endif

endmodule

// ----- bench/lz77_triple_decoder_test.sv -----
// Self-checking bench for lz77_triple_decoder: directed table, then random triples.
// Each item is checked against an in-bench history-ring model. Depends on lzd_pkg and lz77_triple_decoder.
module lz77_triple_decoder_test;
  import lzd_pkg::*;

  localparam int unsigned WINDOW      = LZD_WINDOW_SIZE;
  localparam int unsigned RUN_MAX     = LZD_MAX_LENGTH;
  localparam int unsigned N_DIRECTED  = 16;
  localparam int unsigned N_RANDOM    = 365;
  localparam int unsigned SETTLE      = 150;
  localparam int unsigned IDLE_LIMIT  = 3000;
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } triple_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  lz77_triple_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // history model
  logic [7:0]  history [WINDOW];
  int unsigned wr_ptr = 0;
  int unsigned filled = 0;
  out_item_t   due_bytes[$];

  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  triple_row_t directed_rows [N_DIRECTED];

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  task automatic push_history(input logic [7:0] b);
    history[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % WINDOW;
    if (filled < WINDOW) filled++;
  endtask

  task automatic queue_byte(input out_item_t o);
    due_bytes = {due_bytes, o};
  endtask

  task automatic decode_triple(input in_item_t t);
    int unsigned run;
    int unsigned back;
    logic        skip;
    logic [7:0]  b;
    run  = t.match_length;
    back = t.match_offset;
    if (run > RUN_MAX) run = RUN_MAX;
    skip = (run != 0) && (back == 0 || back > filled);
    if (run != 0 && !skip) begin
      for (int unsigned i = 0; i < run; i++) begin
        b = history[(wr_ptr + WINDOW - back) % WINDOW];
        queue_byte('{data_byte: b, last_of_triple: 1'b0, bad_offset: 1'b0});
        push_history(b);
      end
    end
    queue_byte('{data_byte: t.literal_byte, last_of_triple: 1'b1, bad_offset: skip});
    push_history(t.literal_byte);
  endtask

  task automatic send_triple(input in_item_t t, input logic typed, input out_item_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_triple(t);
    if (typed) due_bytes[due_bytes.size() - 1] = want;
  endtask

  // sender holds off until every byte owed has come out
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (due_bytes.size() != 0);
  endtask

  function automatic in_item_t pick_triple();
    in_item_t    t;
    int unsigned sel;
    int unsigned run;
    int unsigned back;
    sel = $urandom_range(0, 99);
    if (sel < 10)      run = 0;
    else if (sel < 25) run = $urandom_range(1, 3);
    else if (sel < 50) run = $urandom_range(60, 63);
    else               run = $urandom_range(4, 59);
    sel = $urandom_range(0, 99);
    if (run == 0 || filled == 0 || sel < 8) begin
      back = (run == 0 || sel < 4) ? $urandom_range(0, WINDOW) : 0;
    end else if (sel < 16) begin
      back = (filled < WINDOW) ? filled + 1 : $urandom_range(0, WINDOW);
    end else if (sel < 24) begin
      back = $urandom_range(0, WINDOW);
    end else if (sel < 36) begin
      back = filled;
    end else if (sel < 60) begin
      back = $urandom_range(1, (filled < 8) ? filled : 8);
    end else begin
      back = $urandom_range(1, filled);
    end
    t.match_offset = back[OFF_W-1:0];
    t.match_length = run[LEN_W-1:0];
    t.literal_byte = BYTE_W'($urandom_range(0, 255));
    return t;
  endfunction

  // output checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected item byte=%02h", out_item_o.data_byte));
      end else begin
        want = due_bytes.pop_front();
        if (out_item_o.data_byte !== want.data_byte)
          report_mismatch($sformatf("data_byte got %02h want %02h",
                                    out_item_o.data_byte, want.data_byte));
        if (out_item_o.last_of_triple !== want.last_of_triple)
          report_mismatch($sformatf("last_of_triple got %b want %b",
                                    out_item_o.last_of_triple, want.last_of_triple));
        if (out_item_o.bad_offset !== want.bad_offset)
          report_mismatch($sformatf("bad_offset got %b want %b",
                                    out_item_o.bad_offset, want.bad_offset));
      end
    end
  end

  // receiver stall pattern, one of four modes, redrawn at random
  int unsigned stall_cycle = 0;
  int unsigned stall_mode  = 0;
  int unsigned stall_hold  = 0;
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 256 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= (stall_cycle % 7 < 3);
      default: begin
        if (stall_hold != 0) begin
          stall_hold  <= stall_hold - 1;
          out_stall_i <= 1'b1;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_hold  <= $urandom_range(1, 16);
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    endcase
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("lz77_triple_decoder regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    directed_rows = '{
      '{'{13'd0,    6'd0,  8'h00}, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{'{13'd4096, 6'd0,  8'hFF}, 1'b1, '{8'hFF, 1'b1, 1'b0}},
      '{'{13'd0,    6'd5,  8'h11}, 1'b1, '{8'h11, 1'b1, 1'b1}},
      '{'{13'd4,    6'd1,  8'h22}, 1'b1, '{8'h22, 1'b1, 1'b1}},
      '{'{13'd4096, 6'd63, 8'h33}, 1'b1, '{8'h33, 1'b1, 1'b1}},
      '{'{13'd5,    6'd63, 8'h44}, 1'b0, '0},
      '{'{13'd1,    6'd63, 8'hA5}, 1'b0, '0},
      '{'{13'd2,    6'd10, 8'h5A}, 1'b0, '0},
      '{'{13'd1,    6'd1,  8'h80}, 1'b0, '0},
      '{'{13'd146,  6'd20, 8'h7F}, 1'b0, '0},
      '{'{13'h0AAA, 6'd33, 8'h96}, 1'b1, '{8'h96, 1'b1, 1'b1}},
      '{'{13'h0555, 6'd42, 8'h69}, 1'b1, '{8'h69, 1'b1, 1'b1}},
      '{'{13'h0FFF, 6'd21, 8'h01}, 1'b1, '{8'h01, 1'b1, 1'b1}},
      '{'{13'd1,    6'd0,  8'h5A}, 1'b1, '{8'h5A, 1'b1, 1'b0}},
      '{'{13'd169,  6'd63, 8'hC3}, 1'b0, '0},
      '{'{13'd2,    6'd1,  8'h3C}, 1'b0, '0}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < N_DIRECTED; i++)
      send_triple(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    drain_outputs();
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == 170) drain_outputs();
      send_triple(pick_triple(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_count == 0 && due_bytes.size() == 0) begin
      $display("lz77_triple_decoder regression: pass");
    end else begin
      $display("lz77_triple_decoder regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/lzd_pkg.sv
design/lzd_ram.sv
design/lzd_wrap_add.sv
design/lz77_triple_decoder.sv
bench/lz77_triple_decoder_test.sv
